// ===== src/sspq_pkg.sv =====
`timescale 1ns / 1ps

package sspq_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned PRI_W = 8;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_CMP,
    S_FIN
  } state_t;

endpackage

// ===== src/sspq_req_if.sv =====
`timescale 1ns / 1ps

interface sspq_req_if import sspq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic signed [VAL_W-1:0] item_value;
  logic        [PRI_W-1:0] item_priority;

  modport source (output valid, operation, item_value, item_priority, input ready);
  modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

// ===== src/sspq_rsp_if.sv =====
`timescale 1ns / 1ps

interface sspq_rsp_if import sspq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic signed [VAL_W-1:0] out_value;
  logic        [PRI_W-1:0] out_priority;

  modport source (output valid, status, out_value, out_priority, input ready);
  modport sink   (input valid, status, out_value, out_priority, output ready);
endinterface

// ===== src/stable_sorted_priority_queue_top.sv =====
// flow: pop reads the head entry in S_POP_RD, full or empty answers go straight to S_FIN,
// push walks back from the tail, each of the k entries of lower priority moved back one slot
// by a read issued in S_SCAN and a compare in S_CMP, then the new entry is written into the hole
// throughput: one beat at a time, ready again the cycle after the result is registered;
// entries live in a circular buffer so pop never shifts
// reset: synchronous, clears count, head pointer and handshake state; store is never read unwritten
`timescale 1ns / 1ps

module stable_sorted_priority_queue_top import sspq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  sspq_req_if.sink   req,
  sspq_rsp_if.source rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  // store, circular, head is logical position 0
  logic [VAL_W-1:0] mem_val [DEPTH];
  logic [PRI_W-1:0] mem_pri [DEPTH];

  state_t           state, state_next;
  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    cur, cur_next;
  logic [CW-1:0]    left, left_next;
  logic [VAL_W-1:0] op_val, op_val_next;
  logic [PRI_W-1:0] op_pri, op_pri_next;
  status_t          res_status, res_status_next;
  logic [VAL_W-1:0] res_val, res_val_next;
  logic [PRI_W-1:0] res_pri, res_pri_next;

  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_val;
  logic [PRI_W-1:0] rd_pri;
  logic             we;
  logic [AW-1:0]    wa;
  logic [VAL_W-1:0] wv;
  logic [PRI_W-1:0] wp;

  logic             out_valid;
  status_t          out_status;
  logic [VAL_W-1:0] out_val;
  logic [PRI_W-1:0] out_pri;
  logic             slot_free;

  logic [SW-1:0]    tail_sum;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    cur_prev;
  logic [AW-1:0]    head_inc;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_value    = out_val;
  assign rsp.out_priority = out_pri;

  // slot just past the last entry
  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign cur_prev = (cur == '0) ? AW'(DEPTH - 1) : cur - AW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    cur_next        = cur;
    left_next       = left;
    op_val_next     = op_val;
    op_pri_next     = op_pri;
    res_status_next = res_status;
    res_val_next    = res_val;
    res_pri_next    = res_pri;
    rd_addr         = cur_prev;
    we              = 1'b0;
    wa              = cur;
    wv              = op_val;
    wp              = op_pri;

    unique case (state)
      S_IDLE: begin
        rd_addr = head;
        if (req.valid) begin
          res_val_next = '0;
          res_pri_next = '0;
          op_val_next  = req.item_value;
          op_pri_next  = req.item_priority;
          if (req.operation == OP_POP) begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_FIN;
            end else begin
              state_next = S_POP_RD;
            end
          end else begin
            if (count == CW'(DEPTH)) begin
              res_status_next = ST_FULL;
              state_next      = S_FIN;
            end else begin
              cur_next   = tail;
              left_next  = count;
              state_next = S_SCAN;
            end
          end
        end
      end
      S_POP_RD: begin
        res_status_next = ST_POPPED;
        res_val_next    = rd_val;
        res_pri_next    = rd_pri;
        head_next       = head_inc;
        count_next      = count - CW'(1);
        state_next      = S_FIN;
      end
      S_SCAN: begin
        // read of the entry just ahead of the hole is issued here
        if (left == '0) begin
          we              = 1'b1;
          count_next      = count + CW'(1);
          res_status_next = ST_PUSHED;
          state_next      = S_FIN;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_pri >= op_pri) begin
          we              = 1'b1;
          count_next      = count + CW'(1);
          res_status_next = ST_PUSHED;
          state_next      = S_FIN;
        end else begin
          // lower priority entry moves back into the hole
          we         = 1'b1;
          wv         = rd_val;
          wp         = rd_pri;
          cur_next   = cur_prev;
          left_next  = left - CW'(1);
          state_next = S_SCAN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    left       <= left_next;
    op_val     <= op_val_next;
    op_pri     <= op_pri_next;
    res_status <= res_status_next;
    res_val    <= res_val_next;
    res_pri    <= res_pri_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_val[wa] <= wv;
      mem_pri[wa] <= wp;
    end
    rd_val <= mem_val[rd_addr];
    rd_pri <= mem_pri[rd_addr];
  end

  // output register, filled only when it is empty or its previous beat is being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && slot_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && slot_free) begin
      out_status <= res_status;
      out_val    <= res_val;
      out_pri    <= res_pri;
    end
  end

endmodule
